/* hdl/alrd_pkg.sv */
// Shared types and constants for the axis line run detector.
package alrd_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int CNT_W          = 16;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 16;

  localparam logic [CNT_W-1:0] CNT_MAX     = '1;
  localparam logic [CNT_W-1:0] MIN_RUN_RST = 16'd30;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIENTATION = 1'b0,
    REG_MIN_RUN     = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    ORIENT_VERT  = 1'b0,
    ORIENT_HORIZ = 1'b1
  } orient_t;

  typedef struct packed {
    orient_t          orientation;
    logic [CNT_W-1:0] min_run;
  } cfg_t;

  typedef struct packed {
    logic             have_prev;
    logic [CNT_W-1:0] step_count;
  } trk_stat_t;

endpackage

/* hdl/alrd_if.sv */
// Stream interfaces for points in and segments out.
interface alrd_point_if #(
  parameter int COORD_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] point_x;
  logic [COORD_BITS-1:0] point_y;
  logic                  last_point;

  modport source (output valid, output point_x, output point_y, output last_point,
                  input ready);
  modport sink (input valid, input point_x, input point_y, input last_point,
                output ready);
endinterface

interface alrd_seg_if #(
  parameter int COORD_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] seg_start_x;
  logic [COORD_BITS-1:0] seg_start_y;
  logic [COORD_BITS-1:0] seg_end_x;
  logic [COORD_BITS-1:0] seg_end_y;
  logic [COORD_BITS-1:0] seg_length;
  logic                  solid;

  modport source (output valid, output seg_start_x, output seg_start_y,
                  output seg_end_x, output seg_end_y, output seg_length,
                  output solid, input ready);
  modport sink (input valid, input seg_start_x, input seg_start_y,
                input seg_end_x, input seg_end_y, input seg_length,
                input solid, output ready);
endinterface

/* hdl/alrd_in_stage.sv */
// Input register stage for the point stream.
module alrd_in_stage #(
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  alrd_point_if.sink            point,
  input  logic                  drain,
  output logic                  q_valid,
  output logic [COORD_BITS-1:0] q_x,
  output logic [COORD_BITS-1:0] q_y,
  output logic                  q_last
);

  logic load;

  assign point.ready = !q_valid || drain;
  assign load        = point.valid && point.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (load) begin
      q_valid <= 1'b1;
    end else if (drain) begin
      q_valid <= 1'b0;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (load) begin
      q_x    <= point.point_x;
      q_y    <= point.point_y;
      q_last <= point.last_point;
    end
  end

endmodule

/* hdl/alrd_tracker.sv */
// Run state and segment decision for one point per cycle while take is high.
module alrd_tracker #(
  parameter int COORD_BITS = 12
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   take,
  input  alrd_pkg::cfg_t         cfg,
  input  logic [COORD_BITS-1:0]  px,
  input  logic [COORD_BITS-1:0]  py,
  input  logic                   last,
  output logic                   emit,
  output logic [COORD_BITS-1:0]  start_x,
  output logic [COORD_BITS-1:0]  start_y,
  output logic [COORD_BITS-1:0]  end_x,
  output logic [COORD_BITS-1:0]  end_y,
  output logic [COORD_BITS-1:0]  length,
  output logic                   solid,
  output alrd_pkg::trk_stat_t    stat
);
  import alrd_pkg::*;

  logic [COORD_BITS-1:0] prev_x, prev_y;
  logic [COORD_BITS-1:0] run_start_x, run_start_y;
  logic                  have_prev;
  logic [CNT_W-1:0]      step_count;

  logic                  horiz;
  logic [COORD_BITS-1:0] pf, pr, cf, cr, s_ax, e_ax;
  logic [COORD_BITS:0]   pr_inc;
  logic                  cont, brk, emit_brk, emit_last;
  logic [CNT_W-1:0]      cnt_new, cnt_sel;
  logic [COORD_BITS-1:0] start_new_x, start_new_y;

  always_comb begin
    horiz  = (cfg.orientation == ORIENT_HORIZ);
    pf     = horiz ? prev_y : prev_x;
    pr     = horiz ? prev_x : prev_y;
    cf     = horiz ? py : px;
    cr     = horiz ? px : py;
    pr_inc = {1'b0, pr} + 1'b1;
    cont   = have_prev && (cf == pf) && ({1'b0, cr} <= pr_inc);
    brk    = have_prev && !cont;

    if (cont) begin
      cnt_new     = (step_count == CNT_MAX) ? step_count : step_count + 1'b1;
      start_new_x = run_start_x;
      start_new_y = run_start_y;
    end else begin
      cnt_new     = '0;
      start_new_x = px;
      start_new_y = py;
    end

    emit_brk  = brk && (step_count > cfg.min_run);
    emit_last = last && !emit_brk && (cnt_new > cfg.min_run);
    emit      = emit_brk || emit_last;

    // A break closes the run at the previous point; a flush closes it here.
    start_x = emit_brk ? run_start_x : start_new_x;
    start_y = emit_brk ? run_start_y : start_new_y;
    end_x   = emit_brk ? prev_x : px;
    end_y   = emit_brk ? prev_y : py;
    cnt_sel = emit_brk ? step_count : cnt_new;

    s_ax = horiz ? start_x : start_y;
    e_ax = horiz ? end_x : end_y;
    if (e_ax >= s_ax) begin
      length = e_ax - s_ax;
      solid  = (CNT_W'(length) == cnt_sel);
    end else begin
      length = '0;
      solid  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_prev  <= 1'b0;
      step_count <= '0;
    end else if (take) begin
      have_prev  <= !last;
      step_count <= last ? '0 : cnt_new;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      prev_x      <= px;
      prev_y      <= py;
      run_start_x <= start_new_x;
      run_start_y <= start_new_y;
    end
  end

  assign stat.have_prev  = have_prev;
  assign stat.step_count = step_count;

endmodule

/* hdl/alrd_out_reg.sv */
// Result register for the segment stream.
module alrd_out_reg #(
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  logic [COORD_BITS-1:0] start_x,
  input  logic [COORD_BITS-1:0] start_y,
  input  logic [COORD_BITS-1:0] end_x,
  input  logic [COORD_BITS-1:0] end_y,
  input  logic [COORD_BITS-1:0] length,
  input  logic                  solid,
  output logic                  free,
  alrd_seg_if.source            seg
);

  assign free = !seg.valid || seg.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      seg.valid <= 1'b0;
    end else if (load) begin
      seg.valid <= 1'b1;
    end else if (seg.ready) begin
      seg.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      seg.seg_start_x <= start_x;
      seg.seg_start_y <= start_y;
      seg.seg_end_x   <= end_x;
      seg.seg_end_y   <= end_y;
      seg.seg_length  <= length;
      seg.solid       <= solid;
    end
  end

endmodule

/* hdl/axis_line_run_detector_top.sv */
// Top level of the axis line run detector.
// Takes one pixel coordinate per cycle from a sorted point stream and emits a
// segment whenever an axis-aligned run closes with more steps than min_run.
// Orientation 0 follows runs along y at fixed x; 1 follows runs along x at
// fixed y. A point with last_point set flushes the open run and the next
// point starts a fresh stream. Throughput is one point per cycle while the
// result register can take a segment. A point is held in the input register,
// and the segment it closes loads into the result register as the point
// leaves it. That segment then turns valid and transfers out once the sink
// is ready. The input side keeps accepting while a segment waits on the
// output, until both registers are full. Write configuration only while the
// block is idle.
module axis_line_run_detector_top #(
  parameter int COORD_BITS = alrd_pkg::COORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  alrd_point_if.sink                      point,
  alrd_seg_if.source                      seg,
  input  logic                            cfg_we,
  input  logic [alrd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [alrd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import alrd_pkg::*;

  cfg_t                  cfg;
  trk_stat_t             stat;
  logic                  out_free, take, emit;
  logic                  q_valid, q_last;
  logic [COORD_BITS-1:0] q_x, q_y;
  logic [COORD_BITS-1:0] start_x, start_y, end_x, end_y, length;
  logic                  solid;

  // Configuration registers: plain writes, no read-back.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.orientation <= ORIENT_VERT;
      cfg.min_run     <= MIN_RUN_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_ORIENTATION: cfg.orientation <= orient_t'(cfg_data[0]);
        REG_MIN_RUN:     cfg.min_run     <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance the held point whenever the result register can take a segment.
  assign take = q_valid && out_free;

  alrd_in_stage #(.COORD_BITS(COORD_BITS)) u_in (
    .clk     (clk),
    .rst     (rst),
    .point   (point),
    .drain   (out_free),
    .q_valid (q_valid),
    .q_x     (q_x),
    .q_y     (q_y),
    .q_last  (q_last)
  );

  alrd_tracker #(.COORD_BITS(COORD_BITS)) u_trk (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .cfg     (cfg),
    .px      (q_x),
    .py      (q_y),
    .last    (q_last),
    .emit    (emit),
    .start_x (start_x),
    .start_y (start_y),
    .end_x   (end_x),
    .end_y   (end_y),
    .length  (length),
    .solid   (solid),
    .stat    (stat)
  );

  // Load the result register only for points that close a long enough run.
  alrd_out_reg #(.COORD_BITS(COORD_BITS)) u_out (
    .clk     (clk),
    .rst     (rst),
    .load    (take && emit),
    .start_x (start_x),
    .start_y (start_y),
    .end_x   (end_x),
    .end_y   (end_y),
    .length  (length),
    .solid   (solid),
    .free    (out_free),
    .seg     (seg)
  );

`ifndef SYNTHESIS
  // A flushing point leaves no open run behind.
  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    take && q_last |=> !stat.have_prev && (stat.step_count == '0))
    else $error("open run survived a last_point flush");

  // Without a previous point the step count stays at zero.
  a_idle_count: assert property (@(posedge clk) disable iff (rst)
    !stat.have_prev |-> (stat.step_count == '0))
    else $error("step count nonzero with no previous point");

  // No segment can close before any point of the stream is held.
  a_emit_needs_prev: assert property (@(posedge clk) disable iff (rst)
    take && !stat.have_prev |-> !emit)
    else $error("segment emitted without a previous point");
`endif

endmodule
